[design/dfcf_pkg.sv]
// Shared types and constants for the damped fractional comb filter.
// No dependencies; dfcf_ctrl, dfcf_dp and the top level import this package.
package dfcf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_DELAY = 2'd1,
    REG_GAIN  = 2'd2,
    REG_DAMP  = 2'd3
  } cfg_reg_t;

  // register limits and reset values
  localparam logic        [20:0] DELAY_RST = 21'd61440;
  localparam logic        [20:0] DELAY_MIN = 21'd256;
  localparam logic signed [15:0] GAIN_MAX  = 16'sd32440;
  localparam logic signed [15:0] GAIN_MIN  = -16'sd32440;
  localparam logic signed [15:0] GAIN_RST  = 16'sd16384;
  localparam logic        [16:0] DAMP_ONE  = 17'd65536;

  // shared multiplier operand B width (covers 17-bit unsigned damping factor)
  localparam int MB_W = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_INT,
    ST_LP,
    ST_LPMUL,
    ST_UPD,
    ST_GMUL,
    ST_FIN
  } state_t;

  // one strobe per datapath step
  typedef struct packed {
    logic accept;    // latch input, read first tap
    logic ld_m0;     // capture first tap, read second tap
    logic mul_frac;  // frac * (m1 - m0)
    logic lp_err;    // interpolated value minus lowpass state
    logic mul_damp;  // damping factor * error
    logic lp_upd;    // update lowpass state
    logic mul_gain;  // gain * lowpass output
    logic commit;    // saturate, load output, write delay line
  } cmd_t;

endpackage

[design/dfcf_in_if.sv]
// Input sample channel: valid/ready handshake with one signed sample.
// Depends on nothing.
interface dfcf_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[design/dfcf_out_if.sv]
// Result channel: valid/ready handshake with filtered sample and clip flag.
// Depends on nothing.
interface dfcf_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[design/dfcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/dfcf_ctrl.sv]
// Sequencer for the comb filter: steps one transaction through the datapath.
// Depends on dfcf_pkg.
module dfcf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dfcf_pkg::cmd_t cmd
);
  import dfcf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.ld_m0 = 1'b1;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.mul_frac = 1'b1;
        state_nxt    = ST_LP;
      end
      ST_LP: begin
        cmd.lp_err = 1'b1;
        state_nxt  = ST_LPMUL;
      end
      ST_LPMUL: begin
        cmd.mul_damp = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.lp_upd = 1'b1;
        state_nxt  = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/dfcf_dp.sv]
// Datapath: config registers, delay line, interpolation, lowpass, gain, saturation.
// Depends on dfcf_pkg and dfcf_ram.
module dfcf_dp #(
  parameter int DEPTH       = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [dfcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfcf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  dfcf_pkg::cmd_t                        cmd,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic                                  clipped
);
  import dfcf_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(DEPTH);
  localparam int DLW = AW + 8;                          // delay, Q.8 samples
  localparam int CW  = (DLW > CFG_DATA_W) ? DLW : CFG_DATA_W;
  localparam int PW  = SB + 1 + MB_W;                   // product width

  localparam logic [CW-1:0]  DMAX    = CW'((DEPTH - 1) * 256);
  localparam logic [DLW-1:0] D_RST   = (61440 > (DEPTH - 1) * 256) ?
                                       DLW'((DEPTH - 1) * 256) : DLW'(61440);
  localparam logic [DLW:0]   SPAN    = (DLW + 1)'(DEPTH * 256);
  localparam logic [AW-1:0]  LAST    = AW'(DEPTH - 1);
  localparam logic signed [SB+1:0] SMAX = {3'b000, {(SB-1){1'b1}}};
  localparam logic signed [SB+1:0] SMIN = {3'b111, {(SB-1){1'b0}}};

  // ---------------- configuration (stored already clamped) ----------------
  logic                    mode_r;
  logic [DLW-1:0]          delay_r;
  logic signed [15:0]      gain_r;
  logic [16:0]             kd_r;       // 65536 - clamped damping

  logic [CW-1:0]           dly_w;
  logic [DLW-1:0]          dly_clamped;
  logic signed [15:0]      gain_w, gain_clamped;
  logic [16:0]             damp_w, damp_clamped;

  always_comb begin
    dly_w = CW'(cfg_data);
    if (dly_w < CW'(DELAY_MIN)) begin
      dly_clamped = DLW'(DELAY_MIN);
    end else if (dly_w > DMAX) begin
      dly_clamped = DLW'(DMAX);
    end else begin
      dly_clamped = DLW'(dly_w);
    end
    gain_w = signed'(cfg_data[15:0]);
    if (gain_w > GAIN_MAX) begin
      gain_clamped = GAIN_MAX;
    end else if (gain_w < GAIN_MIN) begin
      gain_clamped = GAIN_MIN;
    end else begin
      gain_clamped = gain_w;
    end
    damp_w       = cfg_data[16:0];
    damp_clamped = (damp_w > DAMP_ONE) ? DAMP_ONE : damp_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      delay_r <= D_RST;
      gain_r  <= GAIN_RST;
      kd_r    <= DAMP_ONE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode_r  <= cfg_data[0];
        REG_DELAY: delay_r <= dly_clamped;
        REG_GAIN:  gain_r  <= gain_clamped;
        REG_DAMP:  kd_r    <= DAMP_ONE - damp_clamped;
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  // ---------------- write pointer and lap tracking ----------------
  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrapped_r, wrapped_nxt;

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (cmd.commit) begin
      if (wp_r == LAST) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // ---------------- read position ----------------
  logic signed [DLW+1:0] pos_raw;
  logic [DLW-1:0]        pos;
  logic [AW-1:0]         i0, i1;

  always_comb begin
    pos_raw = signed'({2'b00, wp_r, 8'h00}) - signed'({2'b00, delay_r});
    if (pos_raw < 0) begin
      pos = DLW'(pos_raw + signed'({1'b0, SPAN}));
    end else begin
      pos = DLW'(pos_raw);
    end
    i0 = pos[DLW-1:8];
    i1 = (i0 == LAST) ? '0 : i0 + AW'(1);
  end

  // ---------------- per-transaction registers ----------------
  logic [AW-1:0]           i1_r;
  logic [7:0]              frac_r;
  logic                    v0_r, v1_r;
  logic signed [SB-1:0]    x_in_r;
  logic signed [SB-1:0]    m0_r;
  logic signed [SB:0]      e_r;
  logic signed [SB-1:0]    s_r;       // lowpass state
  logic signed [PW-1:0]    prod_r;

  logic [AW-1:0]           raddr;
  logic [SB-1:0]           rdata;
  logic signed [SB-1:0]    tap;
  logic                    ram_we;
  logic [SB-1:0]           ram_wdata;

  assign raddr = cmd.accept ? i0 : i1_r;

  // entries not yet written in the first lap read as zero
  always_comb begin
    if (cmd.ld_m0) begin
      tap = v0_r ? signed'(rdata) : '0;
    end else begin
      tap = v1_r ? signed'(rdata) : '0;
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [SB:0]      mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd.mul_frac) begin
      mul_a = (SB + 1)'(tap) - (SB + 1)'(m0_r);
      mul_b = signed'({(MB_W - 8)'(0), frac_r});
    end else if (cmd.mul_damp) begin
      mul_a = e_r;
      mul_b = signed'({1'b0, kd_r});
    end else if (cmd.mul_gain) begin
      mul_a = (SB + 1)'(s_r);
      mul_b = MB_W'(gain_r);
    end else begin
      mul_a = '0;
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // arithmetic shifts give floor division by powers of two
  logic signed [PW-1:0]  sh8, sh15, sh16;
  logic signed [SB+1:0]  e_wide, y_wide, sum_wide;
  logic signed [SB-1:0]  sum_sat;
  logic                  sum_clip;

  assign sh8  = prod_r >>> 8;
  assign sh15 = prod_r >>> 15;
  assign sh16 = prod_r >>> 16;

  always_comb begin
    e_wide   = (SB + 2)'(m0_r) + (SB + 2)'(sh8) - (SB + 2)'(s_r);
    y_wide   = (SB + 2)'(s_r) + (SB + 2)'(sh16);
    sum_wide = (SB + 2)'(x_in_r) + (SB + 2)'(sh15);
    if (sum_wide > SMAX) begin
      sum_sat  = SB'(SMAX);
      sum_clip = 1'b1;
    end else if (sum_wide < SMIN) begin
      sum_sat  = SB'(SMIN);
      sum_clip = 1'b1;
    end else begin
      sum_sat  = SB'(sum_wide);
      sum_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (cmd.lp_upd) begin
      s_r <= SB'(y_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_in_r <= sample_in;
      i1_r   <= i1;
      frac_r <= pos[7:0];
      v0_r   <= wrapped_r || (i0 < wp_r);
      v1_r   <= wrapped_r || (i1 < wp_r);
    end
    if (cmd.ld_m0) begin
      m0_r <= tap;
    end
    if (cmd.mul_frac || cmd.mul_damp || cmd.mul_gain) begin
      prod_r <= mul_p;
    end
    if (cmd.lp_err) begin
      e_r <= (SB + 1)'(e_wide);
    end
    if (cmd.commit) begin
      sample_out <= sum_sat;
      clipped    <= sum_clip;
    end
  end

  assign ram_we    = cmd.commit;
  assign ram_wdata = mode_r ? sum_sat : x_in_r;

  dfcf_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

[design/damped_fractional_comb_filter.sv]
// Top level of the damped fractional-delay comb filter.
// Depends on dfcf_pkg, dfcf_in_if, dfcf_out_if, dfcf_ctrl, dfcf_dp, dfcf_ram.
//
// One signed sample in, one saturated sample plus clip flag out per transaction.
// The delay line is one RAM with a single registered read port, so the two
// neighboring taps are read in consecutive cycles, and one multiplier is shared
// by the interpolation, the lowpass and the gain steps, each followed by a
// register. A new sample is accepted once the previous one has reached the
// output register, so samples are taken one at a time and not overlapped; an
// unclaimed result holds the block in its last step. There is no clearing pass
// after reset: until the write pointer has made its first lap, taps that were
// never written read as zero. Configuration writes (cfg_we/cfg_index/cfg_data)
// take effect on the next edge and are clamped on the way in; write them only
// while no transaction is in flight.
module damped_fractional_comb_filter #(
  parameter int DEPTH       = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dfcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfcf_pkg::CFG_DATA_W-1:0] cfg_data,
  dfcf_in_if.sink                         in_ch,
  dfcf_out_if.source                      out_ch
);
  import dfcf_pkg::*;

  cmd_t cmd;

  // sequencer: handshakes and step strobes
  dfcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // arithmetic, config registers and delay memory
  dfcf_dp #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (in_ch.sample_in),
    .sample_out (out_ch.sample_out),
    .clipped    (out_ch.clipped)
  );

  // only one datapath step may be active in any cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath step active");

  // one sample at a time: no acceptance right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  // a committed result is presented on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented");

endmodule

[tb/dfcf_response_check.sv]
// Predicts and checks the filtered samples of the damped fractional comb filter.
// Watches the configuration port and both channels; imports dfcf_pkg.
`timescale 1ns / 1ps

module dfcf_response_check #(
  parameter int DEPTH       = 8192,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [dfcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfcf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [SAMPLE_BITS-1:0]         out_sample,
  input  logic                                  out_clipped,
  output int                                    n_mismatch,
  output int                                    n_pending,
  output int                                    n_checked,
  output int                                    n_clipped
);
  import dfcf_pkg::*;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MAX_PRINT = 40;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } filter_out_t;

  // shadow registers, raw as written; limits are applied at use
  logic                          mode_fb;
  logic [20:0]                   delay_q8;
  logic signed [15:0]            gain_q15;
  logic [16:0]                   damp_q16;

  logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  longint                        lp_state;

  filter_out_t                   expected_out [$];
  int                            mismatches;
  int                            checked;
  int                            clips;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINT)
      $display("%0t ns: mismatch on %s after %0d results: got %0d, expected %0d",
               $time, what, checked, got, want);
    mismatches++;
  endtask

  // one sample through tap interpolation, damping lowpass, gain and saturation
  function automatic filter_out_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
    longint      smax, smin, d, pos, frac, m0, m1, tap, dc, lp, g, acc;
    int          i0, i1;
    filter_out_t r;
    smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    smin = -smax - 1;

    d = longint'(delay_q8);
    if (d < 256) d = 256;
    if (d > longint'(DEPTH - 1) * 256) d = longint'(DEPTH - 1) * 256;
    pos = longint'(wr_ptr) * 256 - d;
    if (pos < 0) pos += longint'(DEPTH) * 256;
    i0   = int'(pos >>> 8);
    frac = pos & 255;
    i1   = (i0 == DEPTH - 1) ? 0 : i0 + 1;

    m0  = longint'(line_mem[i0]);
    m1  = longint'(line_mem[i1]);
    tap = m0 + ((frac * (m1 - m0)) >>> 8);

    dc = longint'(damp_q16);
    if (dc > longint'(DAMP_ONE)) dc = longint'(DAMP_ONE);
    lp = lp_state + (((longint'(DAMP_ONE) - dc) * (tap - lp_state)) >>> 16);
    lp_state = lp;

    g = longint'(gain_q15);
    if (g > longint'(GAIN_MAX)) g = longint'(GAIN_MAX);
    if (g < longint'(GAIN_MIN)) g = longint'(GAIN_MIN);

    acc = longint'(x) + ((g * lp) >>> 15);
    r.clipped = 1'b0;
    if (acc > smax) begin
      acc = smax;
      r.clipped = 1'b1;
    end
    if (acc < smin) begin
      acc = smin;
      r.clipped = 1'b1;
    end
    r.sample = acc[SAMPLE_BITS-1:0];

    line_mem[wr_ptr] = mode_fb ? r.sample : x;
    wr_ptr = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    filter_out_t want;
    if (!rst_n) begin
      mode_fb  = 1'b0;
      delay_q8 = DELAY_RST;
      gain_q15 = GAIN_RST;
      damp_q16 = '0;
      for (int i = 0; i < DEPTH; i++) line_mem[i] = '0;
      wr_ptr   = '0;
      lp_state = 0;
      expected_out.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:  mode_fb  = cfg_data[0];
          REG_DELAY: delay_q8 = cfg_data[20:0];
          REG_GAIN:  gain_q15 = cfg_data[15:0];
          REG_DAMP:  damp_q16 = cfg_data[16:0];
          default: ;
        endcase
      end
      // results are retired before new samples are predicted
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_sample, 0);
        end else begin
          want = expected_out.pop_front();
          if (out_sample !== want.sample)
            report_mismatch("sample_out", out_sample, want.sample);
          if (out_clipped !== want.clipped)
            report_mismatch("clipped", out_clipped, want.clipped);
          if (want.clipped) clips++;
          checked++;
        end
      end
      if (in_valid && in_ready)
        expected_out.push_back(filter_sample(in_sample));
    end
    n_mismatch <= mismatches;
    n_pending  <= expected_out.size();
    n_checked  <= checked;
    n_clipped  <= clips;
  end

endmodule

[tb/tb.sv]
// Testbench top for the damped fractional comb filter: clock, reset, register
// programming, sample stimulus and verdict. Needs dfcf_pkg, both channel
// interfaces, the filter itself and dfcf_response_check.
`timescale 1ns / 1ps

module tb;
  import dfcf_pkg::*;

  localparam int DEPTH         = 8192;
  localparam int SAMPLE_BITS   = 24;
  localparam int RANDOM_ITEMS  = 1250;
  // the limit leaves lots of margin over the slowest legal run (transactions,
  // sender gaps, receiver stalls, one long hold)
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 400;
  localparam int SETTLE_CYCLES = 12;

  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [20:0]            DELAY_TOP = 21'((DEPTH - 1) * 256);

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  dfcf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  dfcf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  int n_mismatch;
  int n_pending;
  int n_checked;
  int n_clipped;

  int cycle_count = 0;
  int n_sent      = 0;
  int burst_left  = 0;
  int n_phases    = 0;

  // samples of the current filter setting, in send order
  logic [SAMPLE_BITS-1:0] phase_q [$];

  damped_fractional_comb_filter #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dfcf_response_check #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) resp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_sample   (in_ch.sample_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_sample  (out_ch.sample_out),
    .out_clipped (out_ch.clipped),
    .n_mismatch  (n_mismatch),
    .n_pending   (n_pending),
    .n_checked   (n_checked),
    .n_clipped   (n_clipped)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, n_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // All four registers, one per cycle. Bits above a register's width may
  // carry junk, which the block must ignore.
  task automatic program_filter(input bit m, input logic [20:0] dly, input logic [15:0] g,
                                input logic [16:0] dmp, input bit junk);
    logic [CFG_DATA_W-1:0] hi;
    hi = junk ? CFG_DATA_W'($urandom) : '0;
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {hi[20:1], m};
    @(posedge clk);
    cfg_index <= REG_DELAY;
    cfg_data  <= dly;
    @(posedge clk);
    cfg_index <= REG_GAIN;
    cfg_data  <= {hi[20:16], g};
    @(posedge clk);
    cfg_index <= REG_DAMP;
    cfg_data  <= {hi[20:17], dmp};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sends phase_q in bursts of random length with random gaps. valid stays
  // high across a burst, so back-to-back transactions see the block's own
  // backpressure; random gaps land on every step of its work.
  task automatic play_phase();
    int gap;
    while (phase_q.size() > 0) begin
      in_ch.valid     <= 1'b1;
      in_ch.sample_in <= phase_q.pop_front();
      do @(posedge clk); while (!in_ch.ready);
      n_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && phase_q.size() > 0) begin
        burst_left = $urandom_range(24, 1);
        gap        = $urandom_range(14, 1);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Registers may only change with nothing in flight. Every sample yields a
  // result, so an empty expectation queue plus a short settle means idle.
  task automatic wait_idle();
    do @(posedge clk); while (n_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: epochs of random length, each with its own stall density
  // (never, one in four, three in four). Once, mid-run, it holds ready low for
  // a long stretch while the sender is offering, so the block backs up.
  initial begin
    int  epoch;
    int  level;
    int  n_taken;
    bit  held_off;
    n_taken  = 0;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      epoch = $urandom_range(200, 20);
      level = $urandom_range(2);
      repeat (epoch) begin
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) n_taken++;
        if (!held_off && n_taken >= HOLD_AFTER && in_ch.valid) begin
          held_off = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (level)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(3) != 0);
            default: out_ch.ready <= ($urandom_range(3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int                     n_items;
    int                     n_random;
    bit                     mode_pick;
    logic [20:0]            dly;
    logic [15:0]            g;
    logic [16:0]            dmp;
    logic [SAMPLE_BITS-1:0] s;

    n_random = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_MODE;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---

    // reset settings: memory is all zero, so the input passes straight through
    phase_q = '{SMAX, SMIN};
    play_phase();
    wait_idle();
    n_phases++;

    // feedback, delay below range (clamps to one sample), gain above range:
    // drive to both rails
    program_filter(1'b1, 21'd0, 16'h7FFF, 17'd0, 1'b0);
    phase_q = '{SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, '0, '1,
                SAMPLE_BITS'(1)};
    play_phase();
    wait_idle();
    n_phases++;

    // delay above range, gain below range, damping above one: lowpass holds
    program_filter(1'b0, 21'h1FFFFF, 16'h8000, 17'h1FFFF, 1'b0);
    phase_q = '{SMAX, 24'h123456, SMIN};
    play_phase();
    wait_idle();
    n_phases++;

    // fractional delay of 1.5 samples, positive gain limit, half damping
    program_filter(1'b0, 21'd384, GAIN_MAX, 17'd32768, 1'b0);
    phase_q = '{SMAX, SMIN, SMAX, SMIN, SMAX};
    play_phase();
    wait_idle();
    n_phases++;

    // feedback, odd fractional delay, negative gain limit, damping exactly one,
    // junk in the unused upper bits of every register write
    program_filter(1'b1, 21'd300, GAIN_MIN, DAMP_ONE, 1'b1);
    phase_q = '{SMIN, SMIN, 24'h000100};
    play_phase();
    wait_idle();
    n_phases++;

    // --- random part: one random setting per phase ---
    while (n_random < RANDOM_ITEMS) begin
      n_items   = $urandom_range(180, 40);
      mode_pick = 1'($urandom_range(1));

      // mostly short delays so the taps see recent samples
      case ($urandom_range(9))
        0:       dly = 21'($urandom_range(255));
        1:       dly = DELAY_MIN;
        2:       dly = DELAY_TOP;
        3:       dly = 21'($urandom_range(21'h1FFFFF, DELAY_TOP + 1));
        4:       dly = 21'($urandom_range(DELAY_TOP, 21'((DEPTH - 1400) * 256)));
        // just past the write pointer: the first read straddles the wrap
        5:       dly = 21'((n_sent % DEPTH) * 256 + $urandom_range(256, 1));
        default: dly = 21'($urandom_range(64 * 256, 256));
      endcase

      case ($urandom_range(7))
        0:       g = GAIN_MAX;
        1:       g = GAIN_MIN;
        2:       g = 16'($urandom_range(32767, 32441));
        3:       g = 16'(-$urandom_range(32768, 32441));
        4:       g = 16'($urandom_range(65535));
        5:       g = 16'(-$urandom_range(32440, 8192));
        default: g = 16'($urandom_range(32440, 8192));
      endcase

      case ($urandom_range(6))
        0:       dmp = '0;
        1:       dmp = DAMP_ONE;
        2:       dmp = 17'($urandom_range(131071, 65537));
        3:       dmp = 17'($urandom_range(65535));
        default: dmp = 17'($urandom_range(49152));
      endcase

      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(9))
          0:       s = SMAX;
          1:       s = SMIN;
          2:       s = SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
          3:       s = SAMPLE_BITS'($urandom_range(2097151)) - SAMPLE_BITS'(1048576);
          default: s = SAMPLE_BITS'($urandom);
        endcase
        phase_q.push_back(s);
      end

      program_filter(mode_pick, dly, g, dmp, $urandom_range(3) == 0);
      play_phase();
      wait_idle();
      n_random += n_items;
      n_phases++;
    end

    // all stimulus accepted: let the last results drain, then settle
    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples over %0d filter settings, checked %0d results, %0d clipped.",
             n_sent, n_phases, n_checked, n_clipped);
    $display("Covered both modes, clamped delays, gains and damping, and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (n_mismatch == 0 && n_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_mismatch, n_pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
